// ===== rtl/kdlp_pkg.sv =====
// Package with shared types and codes for the key debouncer with long press and repeat.
`timescale 1ns / 1ps

package kdlp_pkg;

  // Widths of the tick data, the event codes and the configuration register index.
  localparam int TICK_W  = 32;
  localparam int EVENT_W = 3;
  localparam int INDEX_W = 3;

  // Event codes carried on the result channel.
  localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_PRESSED   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_SHORT_REL = 3'd2;
  localparam logic [EVENT_W-1:0] EV_LONG      = 3'd3;
  localparam logic [EVENT_W-1:0] EV_LONG_REL  = 3'd4;
  localparam logic [EVENT_W-1:0] EV_REPEAT    = 3'd5;

  // Configuration register indexes.
  localparam logic [INDEX_W-1:0] REG_ENABLE          = 3'd0;
  localparam logic [INDEX_W-1:0] REG_PRESS_LOW       = 3'd1;
  localparam logic [INDEX_W-1:0] REG_DEBOUNCE        = 3'd2;
  localparam logic [INDEX_W-1:0] REG_LONG_PRESS      = 3'd3;
  localparam logic [INDEX_W-1:0] REG_REPEAT_START    = 3'd4;
  localparam logic [INDEX_W-1:0] REG_REPEAT_INTERVAL = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [TICK_W-1:0] RST_DEBOUNCE        = 32'd20;
  localparam logic [TICK_W-1:0] RST_LONG_PRESS      = 32'd1000;
  localparam logic [TICK_W-1:0] RST_REPEAT_START    = 32'd500;
  localparam logic [TICK_W-1:0] RST_REPEAT_INTERVAL = 32'd100;

  // Configuration as seen by the key state machine.
  typedef struct packed {
    logic              enable;
    logic              press_low;
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] long_press_ticks;
    logic [TICK_W-1:0] repeat_start_ticks;
    logic [TICK_W-1:0] repeat_interval_ticks;
  } cfg_t;

endpackage

// ===== rtl/kdlp_cfg.sv =====
// Configuration register file with a plain write port.
`timescale 1ns / 1ps

module kdlp_cfg
  import kdlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]  cfg_wdata,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index; indexes past the list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ENABLE:          cfg_nxt.enable                = cfg_wdata[0];
        REG_PRESS_LOW:       cfg_nxt.press_low             = cfg_wdata[0];
        REG_DEBOUNCE:        cfg_nxt.debounce_ticks        = cfg_wdata;
        REG_LONG_PRESS:      cfg_nxt.long_press_ticks      = cfg_wdata;
        REG_REPEAT_START:    cfg_nxt.repeat_start_ticks    = cfg_wdata;
        REG_REPEAT_INTERVAL: cfg_nxt.repeat_interval_ticks = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable                <= 1'b1;
      cfg_r.press_low             <= 1'b1;
      cfg_r.debounce_ticks        <= RST_DEBOUNCE;
      cfg_r.long_press_ticks      <= RST_LONG_PRESS;
      cfg_r.repeat_start_ticks    <= RST_REPEAT_START;
      cfg_r.repeat_interval_ticks <= RST_REPEAT_INTERVAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/kdlp_fsm.sv =====
// Key phase state machine: polarity, elapsed-time compare and event decode.
`timescale 1ns / 1ps

module kdlp_fsm
  import kdlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               raw_pin,
  input  logic [TICK_W-1:0]  now_ticks,
  input  cfg_t               cfg,
  output logic [EVENT_W-1:0] event_code,
  output logic               logical_level
);

  // Phase codes of the key.
  localparam logic [2:0] PH_RELEASED = 3'd0;
  localparam logic [2:0] PH_DEBOUNCE = 3'd1;
  localparam logic [2:0] PH_PRESSED  = 3'd2;
  localparam logic [2:0] PH_LONG     = 3'd3;
  localparam logic [2:0] PH_REPEAT   = 3'd4;

  logic [2:0]        phase_r;
  logic [2:0]        phase_nxt;
  logic [TICK_W-1:0] mark_r;
  logic [TICK_W-1:0] mark_nxt;
  logic [TICK_W-1:0] repeat_r;
  logic [TICK_W-1:0] repeat_nxt;

  logic              level;
  logic              held;
  logic [TICK_W-1:0] stamp;
  logic [TICK_W-1:0] thresh;
  logic [TICK_W-1:0] elapsed;
  logic              expired;
  logic [EVENT_W-1:0] ev;

  // Normalize the pin: 0 means pressed.
  assign level = cfg.press_low ? raw_pin : ~raw_pin;
  assign held  = ~level;

  // One wrapping subtract and compare, with stamp and threshold picked by phase.
  assign stamp = (phase_r == PH_REPEAT) ? repeat_r : mark_r;

  always_comb begin
    case (phase_r)
      PH_DEBOUNCE: thresh = cfg.debounce_ticks;
      PH_PRESSED:  thresh = cfg.long_press_ticks;
      PH_LONG:     thresh = cfg.repeat_start_ticks;
      default:     thresh = cfg.repeat_interval_ticks;
    endcase
  end

  assign elapsed = now_ticks - stamp;
  assign expired = (elapsed >= thresh);

  // Next phase and event for this beat.
  always_comb begin
    phase_nxt  = phase_r;
    mark_nxt   = mark_r;
    repeat_nxt = repeat_r;
    ev         = EV_NONE;
    unique case (phase_r)
      PH_RELEASED: begin
        if (held) begin
          phase_nxt = PH_DEBOUNCE;
          mark_nxt  = now_ticks;
        end
      end
      PH_DEBOUNCE: begin
        if (!held) begin
          phase_nxt = PH_RELEASED;
        end else if (expired) begin
          phase_nxt = PH_PRESSED;
          mark_nxt  = now_ticks;
          ev        = EV_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (!held) begin
          phase_nxt = PH_RELEASED;
          ev        = EV_SHORT_REL;
        end else if (expired) begin
          phase_nxt = PH_LONG;
          mark_nxt  = now_ticks;
          ev        = EV_LONG;
        end
      end
      PH_LONG: begin
        if (!held) begin
          phase_nxt = PH_RELEASED;
          ev        = EV_LONG_REL;
        end else if (expired) begin
          phase_nxt  = PH_REPEAT;
          repeat_nxt = now_ticks;
        end
      end
      PH_REPEAT: begin
        if (!held) begin
          phase_nxt = PH_RELEASED;
        end else if (expired) begin
          repeat_nxt = now_ticks;
          ev         = EV_REPEAT;
        end
      end
      default: begin
        phase_nxt = PH_RELEASED;
      end
    endcase
  end

  // While disabled the state holds and the result reads as released.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_RELEASED;
      mark_r   <= '0;
      repeat_r <= '0;
    end else if (step && cfg.enable) begin
      phase_r  <= phase_nxt;
      mark_r   <= mark_nxt;
      repeat_r <= repeat_nxt;
    end
  end

  assign event_code    = cfg.enable ? ev : EV_NONE;
  assign logical_level = cfg.enable ? level : 1'b1;

endmodule

// ===== rtl/key_debounce_long_press_repeat.sv =====
// Top level of the key debouncer with long press and auto-repeat.
`timescale 1ns / 1ps

// Usage:
//   Input channel: one beat per scan carries in_raw_pin and in_now_ticks.
//   A beat is taken when in_valid is high and in_stall is low.
//   Result channel: one beat per scan carries out_event_code and
//   out_logical_level; it is taken when out_valid is high and out_stall low.
//   Configuration: cfg_wr_en writes cfg_wdata to the register at cfg_index
//   (0 enable, 1 pin polarity, 2..5 tick thresholds); write only when idle.
//   An input beat passes through the input register, from which the phase
//   machine updates as the beat leaves, and then through the result
//   register. Throughput is one scan per cycle while the receiver does not
//   stall, set by the elapsed-time compare and phase update.
//   When the receiver stalls, the result register holds its beat and the
//   input register fills; in_stall rises only when both are occupied.
//   Synchronous reset (rst_n low) empties both registers, puts the key in
//   the released phase with zero time stamps and loads the default
//   configuration.
module key_debounce_long_press_repeat
  import kdlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_raw_pin,
  input  logic [TICK_W-1:0]  in_now_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [EVENT_W-1:0] out_event_code,
  output logic               out_logical_level,
  input  logic               cfg_wr_en,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]  cfg_wdata
);

  cfg_t cfg;

  logic               s1_valid_r;
  logic               s1_raw_r;
  logic [TICK_W-1:0]  s1_now_r;
  logic               out_valid_r;
  logic [EVENT_W-1:0] out_code_r;
  logic               out_level_r;

  logic               out_ready;
  logic               s1_fire;
  logic               in_fire;
  logic [EVENT_W-1:0] fsm_code;
  logic               fsm_level;

  kdlp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kdlp_fsm u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_fire),
    .raw_pin       (s1_raw_r),
    .now_ticks     (s1_now_r),
    .cfg           (cfg),
    .event_code    (fsm_code),
    .logical_level (fsm_level)
  );

  // Pipeline handshake: the result register frees when empty or taken.
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_fire   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_raw_r <= in_raw_pin;
      s1_now_r <= in_now_ticks;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_code_r  <= fsm_code;
      out_level_r <= fsm_level;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_code    = out_code_r;
  assign out_logical_level = out_level_r;

  // Press-type events are only reported with the key held down.
  a_press_level : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_code_r == EV_PRESSED || out_code_r == EV_LONG ||
                    out_code_r == EV_REPEAT) |-> !out_level_r)
    else $error("press event reported with released level");

  // Release events are only reported with the key up.
  a_release_level : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_code_r == EV_SHORT_REL || out_code_r == EV_LONG_REL)
    |-> out_level_r)
    else $error("release event reported with pressed level");

  // A beat leaving the input register lands in the result register.
  a_advance : assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("beat lost between input and result registers");

  // Backpressure only appears with both registers occupied.
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free register");

endmodule
